// ----- hw/rtl/msacp_pkg.sv -----
// ----------------------------------------------------------------------------
// msacp_pkg: shared definitions of the alignment-column pair extractor
// Symbol codes, command codes, field widths and the lane control bundle.
// ----------------------------------------------------------------------------
package msacp_pkg;

    localparam int MAX_SEQUENCES_DEF = 16;
    localparam int COORD_BITS_DEF    = 32;

    localparam int CODE_W   = 3;
    localparam int SEL_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int ACTIVE_W = 5;
    localparam int OUT_COORD_W = 32;

    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 72;

    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

    // Codes below CODE_N are true bases; codes at or above CODE_GAP are gaps.
    localparam logic [CODE_W-1:0] CODE_N   = 3'd4;
    localparam logic [CODE_W-1:0] CODE_GAP = 3'd5;

    localparam logic CMD_COLUMN = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    typedef struct packed {
        logic             col_fire;
        logic             load_fire;
        logic [SEL_W-1:0] sel;
    } t_lane_ctrl;

endpackage

// ----- hw/rtl/msacp_lane.sv -----
// ----------------------------------------------------------------------------
// msacp_lane: one sequence lane
// Holds the running coordinate of one sequence, advances it on non-gap
// symbols with saturation, and flags a true base for the merge stage.
// ----------------------------------------------------------------------------
module msacp_lane #(
    parameter int COORD_BITS = msacp_pkg::COORD_BITS_DEF,
    parameter int LANE_INDEX = 0
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  msacp_pkg::t_lane_ctrl               i_ctrl,
    input  logic [msacp_pkg::CODE_W-1:0]        i_code,
    input  logic                                i_in_use,
    input  logic [COORD_BITS-1:0]               i_load_value,
    output logic [COORD_BITS-1:0]               o_pos,
    output logic                                o_base
);

    logic [COORD_BITS-1:0] r_pos;
    logic [COORD_BITS-1:0] n_pos;
    logic                  advance;
    logic                  load;

    assign advance = i_ctrl.col_fire && i_in_use && (i_code < msacp_pkg::CODE_GAP);
    assign load    = i_ctrl.load_fire
                     && (i_ctrl.sel == msacp_pkg::SEL_W'(LANE_INDEX));

    always_comb begin
        n_pos = r_pos;
        if (load) begin
            n_pos = i_load_value;
        end else if (advance && (r_pos != {COORD_BITS{1'b1}})) begin
            n_pos = r_pos + COORD_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else begin
            r_pos <= n_pos;
        end
    end

    assign o_pos  = r_pos;
    assign o_base = i_in_use && (i_code < msacp_pkg::CODE_N);

endmodule

// ----- hw/rtl/msacp_merge.sv -----
// ----------------------------------------------------------------------------
// msacp_merge: anchor selection and pair emission
// Picks the first base lane as anchor, captures the column's coordinates and
// walks the remaining base lanes, one pair per output beat.
// ----------------------------------------------------------------------------
module msacp_merge #(
    parameter int MAX_SEQUENCES = msacp_pkg::MAX_SEQUENCES_DEF,
    parameter int COORD_BITS    = msacp_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_col_fire,
    input  logic [MAX_SEQUENCES-1:0]              i_base_mask,
    input  logic [COORD_BITS-1:0]                 i_pos [MAX_SEQUENCES],
    output logic                                  o_free,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // anchor_seq[3:0], anchor_coord[35:4], other_seq[39:36], other_coord[71:40]
    output logic [msacp_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    output logic                                  o_m_tlast
);

    localparam int LANE_W = $clog2(MAX_SEQUENCES);

    // Column snapshot held while its pairs are sent.
    logic [MAX_SEQUENCES-1:0] r_rem;
    logic [LANE_W-1:0]        r_anchor_lane;
    logic [COORD_BITS-1:0]    r_anchor_coord;
    logic [COORD_BITS-1:0]    r_pos [MAX_SEQUENCES];

    // Output register.
    logic                     r_out_valid;
    logic [LANE_W-1:0]        r_out_anchor_lane;
    logic [COORD_BITS-1:0]    r_out_anchor_coord;
    logic [LANE_W-1:0]        r_out_other_lane;
    logic [COORD_BITS-1:0]    r_out_other_coord;
    logic                     r_out_last;

    logic [MAX_SEQUENCES-1:0] anchor_hot;
    logic [LANE_W-1:0]        anchor_idx;
    logic [COORD_BITS-1:0]    anchor_coord;
    logic [MAX_SEQUENCES-1:0] low_hot;
    logic [LANE_W-1:0]        low_idx;
    logic [COORD_BITS-1:0]    low_coord;
    logic [MAX_SEQUENCES-1:0] n_rem;
    logic                     out_load;

    assign anchor_hot = i_base_mask & (~i_base_mask + MAX_SEQUENCES'(1));
    assign low_hot    = r_rem & (~r_rem + MAX_SEQUENCES'(1));

    always_comb begin
        anchor_idx   = '0;
        anchor_coord = '0;
        low_idx      = '0;
        low_coord    = '0;
        for (int i = 0; i < MAX_SEQUENCES; i++) begin
            if (anchor_hot[i]) begin
                anchor_idx   = anchor_idx | LANE_W'(i);
                anchor_coord = anchor_coord | i_pos[i];
            end
            if (low_hot[i]) begin
                low_idx   = low_idx | LANE_W'(i);
                low_coord = low_coord | r_pos[i];
            end
        end
    end

    assign n_rem    = r_rem & ~low_hot;
    assign out_load = (r_rem != '0) && (!r_out_valid || i_m_tready);
    // A new column may enter as soon as the last pair of this one is registered.
    assign o_free   = (r_rem == '0) || ((n_rem == '0) && out_load);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_rem       <= n_rem;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_col_fire) begin
                r_rem <= i_base_mask & ~anchor_hot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_col_fire) begin
            r_anchor_lane  <= anchor_idx;
            r_anchor_coord <= anchor_coord;
            r_pos          <= i_pos;
        end
        if (out_load) begin
            r_out_anchor_lane  <= r_anchor_lane;
            r_out_anchor_coord <= r_anchor_coord;
            r_out_other_lane   <= low_idx;
            r_out_other_coord  <= low_coord;
            r_out_last         <= (n_rem == '0);
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {msacp_pkg::OUT_COORD_W'(r_out_other_coord),
                         msacp_pkg::SEL_W'(r_out_other_lane),
                         msacp_pkg::OUT_COORD_W'(r_out_anchor_coord),
                         msacp_pkg::SEL_W'(r_out_anchor_lane)};

endmodule

// ----- hw/rtl/msa_column_to_aligned_pairs_unit.sv -----
// ----------------------------------------------------------------------------
// msa_column_to_aligned_pairs_unit: alignment column to aligned base pairs
// Per-sequence lanes keep running coordinates; the merge stage anchors on the
// first base of a column and emits one pair for every later base.
// ----------------------------------------------------------------------------
//  Channel  | Signals                        | Beat contents
//  ---------+--------------------------------+-----------------------------------
//  s (in)   | i_s_tvalid/o_s_tready          | tuser: command; tdata: column_codes,
//           | i_s_tdata/i_s_tuser            | seq_select, coord_value
//  m (out)  | o_m_tvalid/i_m_tready          | tdata: anchor_seq, anchor_coord,
//           | o_m_tdata/o_m_tlast            | other_seq, other_coord; tlast
//  cfg      | i_cfg_wen/i_cfg_wdata          | active_sequences
//
// A column that yields pairs holds the input until its last pair is loaded into the
// output register, since the single pair emitter in the merge stage sends them one
// by one; a column is held in the merge snapshot and its pairs pass the output register.
// Reset clears every coordinate to zero and sets active_sequences to 16.
// A stall on the output holds the current pair and the input stays blocked
// only while the emitter still has pairs of an earlier column to send.
// ----------------------------------------------------------------------------
module msa_column_to_aligned_pairs_unit #(
    parameter int MAX_SEQUENCES = msacp_pkg::MAX_SEQUENCES_DEF,
    parameter int COORD_BITS    = msacp_pkg::COORD_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    // column_codes[47:0], seq_select[51:48], coord_value[83:52], zero[87:84]
    input  logic [msacp_pkg::IN_TDATA_W-1:0]      i_s_tdata,
    // command[0]
    input  logic                                  i_s_tuser,
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    // anchor_seq[3:0], anchor_coord[35:4], other_seq[39:36], other_coord[71:40]
    output logic [msacp_pkg::OUT_TDATA_W-1:0]     o_m_tdata,
    // last_pair
    output logic                                  o_m_tlast,
    input  logic                                  i_cfg_wen,
    input  logic [msacp_pkg::ACTIVE_W-1:0]        i_cfg_wdata
);

    logic [msacp_pkg::ACTIVE_W-1:0] r_active;
    logic                           s_fire;
    logic                           free;
    msacp_pkg::t_lane_ctrl          ctrl;
    logic [COORD_BITS-1:0]          load_value;
    logic [MAX_SEQUENCES-1:0]       base_mask;
    logic [COORD_BITS-1:0]          pos [MAX_SEQUENCES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= msacp_pkg::ACTIVE_RESET;
        end else if (i_cfg_wen) begin
            r_active <= i_cfg_wdata;
        end
    end

    assign o_s_tready    = free;
    assign s_fire        = i_s_tvalid && free;
    assign ctrl.col_fire  = s_fire && (i_s_tuser == msacp_pkg::CMD_COLUMN);
    assign ctrl.load_fire = s_fire && (i_s_tuser == msacp_pkg::CMD_LOAD);
    assign ctrl.sel       = i_s_tdata[51:48];
    assign load_value     = COORD_BITS'(i_s_tdata[83:52]);

    for (genvar g = 0; g < MAX_SEQUENCES; g++) begin : g_lane
        logic in_use;
        // Register values above the lane count cover every lane.
        assign in_use = (msacp_pkg::ACTIVE_W'(g) < r_active);

        msacp_lane #(
            .COORD_BITS (COORD_BITS),
            .LANE_INDEX (g)
        ) u_lane (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_code       (i_s_tdata[3*g +: msacp_pkg::CODE_W]),
            .i_in_use     (in_use),
            .i_load_value (load_value),
            .o_pos        (pos[g]),
            .o_base       (base_mask[g])
        );
    end

    msacp_merge #(
        .MAX_SEQUENCES (MAX_SEQUENCES),
        .COORD_BITS    (COORD_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_col_fire  (ctrl.col_fire),
        .i_base_mask (base_mask),
        .i_pos       (pos),
        .o_free      (free),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
